@@ rtl/pdcu_pkg.sv @@
// ----------------------------------------------------------------------------
// pdcu_pkg
// shared types, register codes and saturation helper for the porous drag
// cell update pipeline
// ----------------------------------------------------------------------------
package pdcu_pkg;

    localparam int COEF_W   = 21;
    localparam int ROW_W    = 3 * COEF_W;
    localparam int WORD_W   = 32;
    localparam int IN_W     = 8 * WORD_W;
    localparam int OUT_W    = 4 * WORD_W;
    localparam int CFG_IDX_W = 3;
    localparam int WIDE_W   = 72;

    localparam logic [WORD_W-1:0] DENSITY_RESET = 32'h0001_0000;

    localparam logic signed [WIDE_W-1:0] S32_MAX = 72'sh00_0000_0000_7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] S32_MIN = 72'shFF_FFFF_FFFF_8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA0  = 3'd0,
        CFG_ALPHA1  = 3'd1,
        CFG_ALPHA2  = 3'd2,
        CFG_BETA0   = 3'd3,
        CFG_BETA1   = 3'd4,
        CFG_BETA2   = 3'd5,
        CFG_DENSITY = 3'd6
    } t_cfg_idx;

    // returns {clipped, value}
    function automatic logic [WORD_W:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [WORD_W:0] res;
        if (v > S32_MAX) begin
            res = {1'b1, S32_MAX[WORD_W-1:0]};
        end else if (v < S32_MIN) begin
            res = {1'b1, S32_MIN[WORD_W-1:0]};
        end else begin
            res = {1'b0, v[WORD_W-1:0]};
        end
        return res;
    endfunction

endpackage

@@ rtl/pdcu_sqrt.sv @@
// ----------------------------------------------------------------------------
// pdcu_sqrt
// pipelined integer square root, one result bit per stage, with side data
// ----------------------------------------------------------------------------
module pdcu_sqrt
    import pdcu_pkg::*;
#(
    parameter int ROOT_W = 32,
    parameter int SIDE_W = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_radicand,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic              r_vld  [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic [RAD_W-1:0]  r_rad  [0:ROOT_W-1];
    logic [SIDE_W-1:0] r_side [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic              p_vld;
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [RAD_W-1:0]  p_rad;
        logic [SIDE_W-1:0] p_side;
        logic [REM_W-1:0]  w_t;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_radicand;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_side = r_side[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign w_t     = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
        assign w_trial = {1'b0, p_root, 2'b01};
        assign w_ge    = (w_t >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? (w_t - w_trial) : w_t;
                r_root[k] <= {p_root[ROOT_W-2:0], w_ge};
                r_rad[k]  <= {p_rad[RAD_W-3:0], 2'b00};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

@@ rtl/porous_drag_cell_update.sv @@
// ----------------------------------------------------------------------------
// porous_drag_cell_update
// porous drag source term update for one mesh cell per request
// ----------------------------------------------------------------------------
// channels: a slave stream takes one cell (velocity, volume, diagonal and
// source accumulators) per request; a master stream returns the updated
// diagonal and source, with tuser set when any value was clipped.
// coefficients and density are written over the cfg channel, which is always
// ready; writes are meant to happen while no cell is in flight.
// the squared speed stages, the square root (one root bit per stage) and the
// drag, trace, product and sum stages follow in that order.
// the fully pipelined datapath takes one cell per cycle while not stalled.
// all stages move together; when the receiver stalls with a result waiting,
// the whole pipeline holds and the slave side drops tready, nothing is lost.
// reset clears the valid bits, zeroes the coefficients and sets density to one.
// ----------------------------------------------------------------------------
module porous_drag_cell_update
    import pdcu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // vel_x, vel_y, vel_z, cell_volume, diag_in, source_in_x/y/z (32 each)
    input  logic [IN_W-1:0]       s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // diag_out, source_out_x, source_out_y, source_out_z (32 each)
    output logic [OUT_W-1:0]      m_axis_tdata,
    // saturated
    output logic                  m_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ROW_W-1:0]      i_cfg_data
);

    localparam int NST = 10;

    logic [ROW_W-1:0]  r_alpha [0:2];
    logic [ROW_W-1:0]  r_beta  [0:2];
    logic [WORD_W-1:0] r_rho;

    logic en;
    assign en            = !(m_axis_tvalid && !m_axis_tready);
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_alpha[i] <= '0;
                r_beta[i]  <= '0;
            end
            // density of one in the configured fixed point format
            r_rho <= WORD_W'(1) << FRAC_BITS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA0:  r_alpha[0] <= i_cfg_data;
                CFG_ALPHA1:  r_alpha[1] <= i_cfg_data;
                CFG_ALPHA2:  r_alpha[2] <= i_cfg_data;
                CFG_BETA0:   r_beta[0]  <= i_cfg_data;
                CFG_BETA1:   r_beta[1]  <= i_cfg_data;
                CFG_BETA2:   r_beta[2]  <= i_cfg_data;
                CFG_DENSITY: r_rho      <= i_cfg_data[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // squared components, then their sum
    logic               r_v0, r_v1;
    logic [63:0]        r_sq [0:2];
    logic [63:0]        r_sum;
    logic [IN_W-1:0]    r_d0, r_d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v0 <= s_axis_tvalid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_sq[j] <= 64'($signed(64'($signed(s_axis_tdata[WORD_W*j +: WORD_W])))
                               * $signed(64'($signed(s_axis_tdata[WORD_W*j +: WORD_W]))));
            end
            r_d0  <= s_axis_tdata;
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_d1  <= r_d0;
        end
    end

    logic              w_sv;
    logic [WORD_W-1:0] w_speed;
    logic [IN_W-1:0]   w_sd;

    pdcu_sqrt #(
        .ROOT_W (WORD_W),
        .SIDE_W (IN_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v1),
        .i_radicand (r_sum),
        .i_side     (r_d1),
        .o_valid    (w_sv),
        .o_root     (w_speed),
        .o_side     (w_sd)
    );

    // post-root stages share a valid/side/flag shift line
    logic            r_vs   [0:NST-1];
    logic [IN_W-1:0] r_side [0:NST-1];
    logic            r_fl   [0:NST-1];

    logic signed [53:0]        r_bs  [0:8];
    logic signed [WORD_W-1:0]  r_a   [0:8];
    logic signed [65:0]        r_ra  [0:8];
    logic signed [WORD_W-1:0]  r_cd  [0:8];
    logic signed [WORD_W-1:0]  r_cde [0:8];
    logic signed [WORD_W-1:0]  r_tr, r_trf;
    logic signed [WORD_W-1:0]  r_m   [0:8];
    logic signed [63:0]        r_mu  [0:8];
    logic signed [65:0]        r_vtr;
    logic signed [WORD_W-1:0]  r_acc [0:2];
    logic signed [WORD_W-1:0]  r_dg, r_dgi, r_dgj;
    logic signed [65:0]        r_va  [0:2];
    logic signed [WORD_W-1:0]  r_src [0:2];

    logic [WORD_W:0] n_a   [0:8];
    logic [WORD_W:0] n_cd  [0:8];
    logic [WORD_W:0] n_tr;
    logic [WORD_W:0] n_m   [0:8];
    logic [WORD_W:0] n_acc [0:2];
    logic [WORD_W:0] n_dg;
    logic [WORD_W:0] n_src [0:2];
    logic            n_fb, n_fd, n_ff, n_fh, n_fj;

    always_comb begin
        n_fb = 1'b0;
        n_fd = 1'b0;
        n_ff = 1'b0;
        n_fh = 1'b0;
        n_fj = 1'b0;
        for (int k = 0; k < 9; k++) begin
            n_a[k]  = sat32(WIDE_W'($signed(r_alpha[k/3][COEF_W*(k%3) +: COEF_W]))
                            + WIDE_W'(r_bs[k] >>> FRAC_BITS));
            n_fb    = n_fb | n_a[k][WORD_W];
            n_cd[k] = sat32(WIDE_W'(r_ra[k] >>> FRAC_BITS));
            n_fd    = n_fd | n_cd[k][WORD_W];
            n_m[k]  = sat32(WIDE_W'(r_cde[k]) - ((k % 4 == 0) ? WIDE_W'(r_tr) : '0));
            n_ff    = n_ff | n_m[k][WORD_W];
        end
        n_tr = sat32(WIDE_W'(r_cd[0]) + WIDE_W'(r_cd[4]) + WIDE_W'(r_cd[8]));
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = sat32(WIDE_W'(r_mu[3*i] >>> FRAC_BITS)
                             + WIDE_W'(r_mu[3*i+1] >>> FRAC_BITS)
                             + WIDE_W'(r_mu[3*i+2] >>> FRAC_BITS));
            n_fh     = n_fh | n_acc[i][WORD_W];
            n_src[i] = sat32(WIDE_W'($signed(r_side[8][5*WORD_W + WORD_W*i +: WORD_W]))
                             + WIDE_W'(r_va[i] >>> FRAC_BITS));
            n_fj     = n_fj | n_src[i][WORD_W];
        end
        n_dg = sat32(WIDE_W'($signed(r_side[6][4*WORD_W +: WORD_W]))
                     + WIDE_W'(r_vtr >>> FRAC_BITS));
        n_fh = n_fh | n_dg[WORD_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_vs[s] <= 1'b0;
            end
        end else if (en) begin
            r_vs[0] <= w_sv;
            for (int s = 1; s < NST; s++) begin
                r_vs[s] <= r_vs[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= w_sd;
            for (int s = 1; s < NST; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_fl[0] <= 1'b0;
            r_fl[1] <= r_fl[0] | n_fb;
            r_fl[2] <= r_fl[1];
            r_fl[3] <= r_fl[2] | n_fd;
            r_fl[4] <= r_fl[3] | n_tr[WORD_W];
            r_fl[5] <= r_fl[4] | n_ff;
            r_fl[6] <= r_fl[5];
            r_fl[7] <= r_fl[6] | n_fh;
            r_fl[8] <= r_fl[7];
            r_fl[9] <= r_fl[8] | n_fj;

            for (int k = 0; k < 9; k++) begin
                // beta times speed
                r_bs[k]  <= 54'($signed(r_beta[k/3][COEF_W*(k%3) +: COEF_W]))
                            * 54'($signed({1'b0, w_speed}));
                r_a[k]   <= n_a[k][WORD_W-1:0];
                r_ra[k]  <= 66'($signed({1'b0, r_rho})) * 66'(r_a[k]);
                r_cd[k]  <= n_cd[k][WORD_W-1:0];
                r_cde[k] <= r_cd[k];
                r_m[k]   <= n_m[k][WORD_W-1:0];
                r_mu[k]  <= 64'(r_m[k])
                            * 64'($signed(r_side[5][WORD_W*(k%3) +: WORD_W]));
            end
            r_tr  <= n_tr[WORD_W-1:0];
            r_trf <= r_tr;
            r_vtr <= 66'($signed({1'b0, r_side[5][3*WORD_W +: WORD_W]})) * 66'(r_trf);
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= n_acc[i][WORD_W-1:0];
                r_va[i]  <= 66'($signed({1'b0, r_side[7][3*WORD_W +: WORD_W]}))
                            * 66'(r_acc[i]);
                r_src[i] <= n_src[i][WORD_W-1:0];
            end
            r_dg  <= n_dg[WORD_W-1:0];
            r_dgi <= r_dg;
            r_dgj <= r_dgi;
        end
    end

    assign m_axis_tvalid = r_vs[NST-1];
    assign m_axis_tuser  = r_fl[NST-1];
    assign m_axis_tdata  = {r_src[2], r_src[1], r_src[0], r_dgj};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_stall_freezes_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_vs[0]) && $stable(r_vs[NST-2]) && $stable(w_sv)))
        else $error("pipeline moved during stall");

    a_output_follows_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vs[NST-2]) |=> m_axis_tvalid)
        else $error("result lost at output stage");

    // data registers start unknown, so compare with case equality
    a_trace_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (r_trf === $past(r_tr)))
        else $error("trace staging broken");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// porous drag cell update testbench
// streams cells through the drag pipeline under several coefficient settings,
// predicts each updated diagonal and source in fixed point and compares them
// in order, with random idling on both stream sides
// ----------------------------------------------------------------------------
module testbench;
    import pdcu_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = 44;

    typedef struct packed {
        logic [WORD_W-1:0] sz;
        logic [WORD_W-1:0] sy;
        logic [WORD_W-1:0] sx;
        logic [WORD_W-1:0] diag;
    } t_update;

    typedef struct {
        t_update data;
        logic    sat;
    } t_drag_result;

    class drag_scoreboard;
        logic [ROW_W-1:0]  alpha [3];
        logic [ROW_W-1:0]  beta [3];
        logic [WORD_W-1:0] rho;
        t_drag_result      pending [$];
        int                errors;

        function void reset_regs();
            for (int i = 0; i < 3; i++) begin
                alpha[i] = '0;
                beta[i] = '0;
            end
            rho = DENSITY_RESET;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [ROW_W-1:0] val);
            case (idx)
                CFG_ALPHA0, CFG_ALPHA1, CFG_ALPHA2: alpha[idx] = val;
                CFG_BETA0, CFG_BETA1, CFG_BETA2: beta[idx - CFG_BETA0] = val;
                CFG_DENSITY: rho = val[WORD_W-1:0];
                default: ;
            endcase
        endfunction

        static function longint fshr(longint v);
            return v >>> FB;
        endfunction

        static function longint clip(longint v, ref logic flag);
            if (v > 64'sd2147483647) begin
                flag = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                flag = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        static function longint coef(logic [ROW_W-1:0] row, int col);
            logic signed [COEF_W-1:0] c;
            c = row[col*COEF_W +: COEF_W];
            return longint'(c);
        endfunction

        // integer square root, one bit per pass
        static function longint root64(logic [63:0] n);
            logic [63:0] r, b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        function void note_cell(logic [IN_W-1:0] item);
            longint u [3];
            longint cd [3][3];
            longint m [3][3];
            longint vol, spd, tr, acc, a;
            logic [63:0] sq;
            logic flag;
            t_drag_result r;
            flag = 1'b0;
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                u[i] = longint'($signed(item[i*WORD_W +: WORD_W]));
                sq = sq + u[i] * u[i];
            end
            vol = longint'({32'd0, item[3*WORD_W +: WORD_W]});
            spd = root64(sq);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    a = clip(coef(alpha[i], j) + fshr(coef(beta[i], j) * spd), flag);
                    cd[i][j] = clip(fshr(longint'({32'd0, rho}) * a), flag);
                end
            end
            tr = clip(cd[0][0] + cd[1][1] + cd[2][2], flag);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m[i][j] = clip(cd[i][j] - (i == j ? tr : 0), flag);
            r.data.diag = WORD_W'(clip(longint'($signed(item[4*WORD_W +: WORD_W])) +
                fshr(vol * tr), flag));
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) acc += fshr(m[i][j] * u[j]);
                acc = clip(acc, flag);
                a = clip(longint'($signed(item[(5+i)*WORD_W +: WORD_W])) +
                    fshr(vol * acc), flag);
                case (i)
                    0: r.data.sx = WORD_W'(a);
                    1: r.data.sy = WORD_W'(a);
                    default: r.data.sz = WORD_W'(a);
                endcase
            end
            r.sat = flag;
            pending.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic sat);
            t_drag_result e;
            t_update got;
            got = data;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h sat %b", $time, data, sat);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.diag !== e.data.diag) begin
                $display("%0t: diag exp %h got %h", $time, e.data.diag, got.diag);
                errors++;
            end
            if (got.sx !== e.data.sx) begin
                $display("%0t: source x exp %h got %h", $time, e.data.sx, got.sx);
                errors++;
            end
            if (got.sy !== e.data.sy) begin
                $display("%0t: source y exp %h got %h", $time, e.data.sy, got.sy);
                errors++;
            end
            if (got.sz !== e.data.sz) begin
                $display("%0t: source z exp %h got %h", $time, e.data.sz, got.sz);
                errors++;
            end
            if (sat !== e.sat) begin
                $display("%0t: saturated exp %b got %b", $time, e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic [IN_W-1:0]    s_axis_tdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ROW_W-1:0]   i_cfg_data = '0;

    drag_scoreboard board = new();
    bit quiet_tail = 1'b0;

    porous_drag_cell_update dut (.*);

    always #10 i_clk = ~i_clk;

    // receiver: random stall bursts until the tail
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 7) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // valid stays high across a run of writes and is dropped by the caller
    task automatic write_cfg(t_cfg_idx idx, logic [ROW_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, val);
    endtask

    task automatic send_cell(logic [IN_W-1:0] item, bit may_idle);
        int gap;
        if (may_idle && !quiet_tail && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= item;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_cell(item);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 8) << 16;
            3: return 32'(signed'($urandom_range(0, 200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] random_cell();
        logic [IN_W-1:0] c;
        for (int k = 0; k < 8; k++) c[k*WORD_W +: WORD_W] = pick_word();
        // mostly moderate volumes so results stay in range
        if ($urandom_range(0, 2) != 0) c[3*WORD_W +: WORD_W] = $urandom_range(0, 4 << 16);
        return c;
    endfunction

    function automatic logic [ROW_W-1:0] random_row(int mode);
        logic [ROW_W-1:0] r;
        logic signed [COEF_W-1:0] c;
        for (int k = 0; k < 3; k++) begin
            case (mode)
                0: c = 0;
                1: c = 21'sh0FFFFF;
                2: c = 21'sh100000;
                default: c = COEF_W'($urandom_range(0, 40000) - 20000);
            endcase
            r[k*COEF_W +: COEF_W] = c;
        end
        return r;
    endfunction

    task automatic load_setting(int mode, logic [WORD_W-1:0] dens);
        for (int i = 0; i < 6; i++) write_cfg(t_cfg_idx'(i),
            mode == 4 ? ROW_W'({$urandom, $urandom}) : random_row(mode));
        write_cfg(CFG_DENSITY, {31'd0, dens});
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [IN_W-1:0] c;
        board.reset_regs();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default setting gives zero drag
        send_cell('0, 0);
        c = '0;
        c[0 +: WORD_W] = 32'h0001_0000;
        c[4*WORD_W +: WORD_W] = 32'h7FFF_FFFF;
        send_cell(c, 0);
        drain();
        load_setting(3, 32'h0001_0000);
        c = '0;
        for (int k = 0; k < 3; k++) c[k*WORD_W +: WORD_W] = 32'h0002_0000;
        c[3*WORD_W +: WORD_W] = 32'h0001_0000;
        send_cell(c, 0);
        for (int k = 0; k < 3; k++) c[k*WORD_W +: WORD_W] = 32'h8000_0000;
        send_cell(c, 0);
        for (int k = 0; k < 8; k++) c[k*WORD_W +: WORD_W] = 32'h7FFF_FFFF;
        send_cell(c, 0);
        for (int k = 0; k < 8; k++) c[k*WORD_W +: WORD_W] = 32'h8000_0000;
        c[3*WORD_W +: WORD_W] = 32'hFFFF_FFFF;
        send_cell(c, 0);
        drain();
        load_setting(1, 32'hFFFF_FFFF);
        send_cell(c, 0);
        c = '1;
        send_cell(c, 0);
        drain();
        load_setting(2, 32'hFFFF_FFFF);
        send_cell(c, 0);
        c = '0;
        c[3*WORD_W +: WORD_W] = 32'hFFFF_FFFF;
        c[5*WORD_W +: WORD_W] = 32'h8000_0000;
        send_cell(c, 0);
        drain();

        // random phases across several settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: load_setting(3, $urandom_range(0, 4 << 16));
                1: load_setting(4, $urandom);
                2: load_setting(3, 32'd0);
                default: load_setting(ph == 7 ? 0 : 3, $urandom_range(1 << 15, 3 << 16));
            endcase
            if (ph == 7) quiet_tail = 1'b1;
            for (int n = 0; n < 200; n++) send_cell(random_cell(), 1);
            drain();
        end

        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pdcu_pkg.sv
rtl/pdcu_sqrt.sv
rtl/porous_drag_cell_update.sv
bench/testbench.sv
